@@ rtl/core/wsg5_pkg.sv @@
package wsg5_pkg;

   // Geometry of the channel set and the shared wave memory.
   localparam int NUM_CHAN   = 5;
   localparam int WAVE_LEN   = 32;
   localparam int WAVE_DEPTH = NUM_CHAN * WAVE_LEN;

   // Request kinds carried in the request's tuser.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Bus address map, after folding the 0x90-0x9f mirror onto 0x80-0x8f.
   localparam logic [7:0] ADDR_PERIOD_LAST = 8'h89;
   localparam logic [7:0] ADDR_VOL_FIRST   = 8'h8a;
   localparam logic [7:0] ADDR_VOL_LAST    = 8'h8e;
   localparam logic [7:0] ADDR_KEY         = 8'h8f;
   localparam logic [7:0] ADDR_TEST        = 8'he0;
   localparam logic [6:0] WAVE_SHARED_BASE = 7'h60;
   localparam logic [2:0] CHAN_SHARED      = 3'd4;
   localparam logic [2:0] CHAN_PREV_SHARED = 3'd3;

   // Test register bits.
   localparam int TEST_CLEAR_POS  = 5;
   localparam int TEST_BLOCK_ALL  = 6;
   localparam int TEST_BLOCK_HIGH = 7;
   localparam logic [7:0] TEST_READ_VALUE = 8'hff;

   // A channel runs only when its period is at least this value.
   localparam logic [11:0] PERIOD_MIN_RUN = 12'd9;
   localparam logic [13:0] ACCUM_STEP     = 14'd32;
   localparam int          DIV_STEPS      = 14;

   // Mix scaling: floor(m * 128 / 5) = (m * MIX_RECIP) >> MIX_SHIFT for m <= 1200.
   localparam logic [18:0] MIX_RECIP = 19'd419431;
   localparam int          MIX_SHIFT = 14;

   // One channel's state as held in the channel memory.
   typedef struct packed {
      logic [11:0] period;
      logic [3:0]  volume;
      logic [4:0]  position;
      logic [12:0] accum;
   } chan_type;

   localparam chan_type CHAN_RESET = '{
      period:   12'd0,
      volume:   4'd15,
      position: 5'd0,
      accum:    13'd0
   };

endpackage

@@ rtl/core/wavetable_sound_generator_5ch.sv @@
// Five-channel wavetable sound generator. Each request carries a kind in tuser (bus write,
// bus read or one sample tick) and an address and write byte in tdata; every request gives
// exactly one response with the read byte and the mixed signed sample, both zero where the
// request kind does not produce them. The 160 wave bytes live in one single-port-per-cycle
// memory and the five channel states (period, volume, position, accumulator) in a second
// small memory; both have registered reads, and per-entry valid bits make entries
// read as their reset values until first written, so no clearing pass is needed after reset.
// Requests are served one at a time. A sample tick visits the channels in turn: a halted
// channel is only read and checked, while a running one also passes through a bit-serial
// remainder divider, a write-back and a multiply-accumulate step; the mixed sum is then
// scaled. A finished response waits in its output register while the next request is
// accepted.
module wavetable_sound_generator_5ch (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] addr, [15:8] wdata
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] rdata, [23:8] sample
);

   import wsg5_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISP,
      S_WAVE_WR2,
      S_CH_RMW,
      S_RD_POS,
      S_RD_WAVE,
      S_TK_RD,
      S_TK_CHK,
      S_TK_DIV,
      S_TK_WB,
      S_TK_MAC,
      S_MIX_ABS,
      S_MIX_MUL,
      S_MIX_OUT,
      S_DONE
   } state_type;

   state_type state_ff;

   // Latched request.
   logic [1:0] cmd_ff;
   logic [7:0] addr_ff;
   logic [7:0] wdata_ff;

   // Registers kept outside the memories.
   logic [7:0] test_ff;
   logic [4:0] key_ff;

   // Tick datapath.
   logic [2:0]         ch_ff;
   chan_type           ent_ff;
   logic [13:0]        dividend_ff;
   logic [12:0]        rem_ff;
   logic [4:0]         quo_ff;
   logic [3:0]         cnt_ff;
   logic signed [11:0] sum_ff;
   logic [10:0]        mag_ff;
   logic               neg_ff;
   logic [29:0]        prod_ff;

   // Pending response and output register.
   logic [7:0]  res_rdata_ff;
   logic [15:0] res_sample_ff;
   logic        rsp_tvalid_ff;
   logic [23:0] rsp_tdata_ff;

   // Wave memory with per-entry valid bits.
   logic [7:0]            wave_mem [WAVE_DEPTH];
   logic [WAVE_DEPTH-1:0] wave_vld_ff;
   logic [7:0]            wave_rdata_ff;
   logic                  wave_rvld_ff;
   logic                  wave_we;
   logic [7:0]            wave_waddr;
   logic                  wave_re;
   logic [7:0]            wave_raddr;
   logic [7:0]            wave_cur;

   // Channel memory with per-entry valid bits.
   chan_type              chan_mem [NUM_CHAN];
   logic [NUM_CHAN-1:0]   chan_vld_ff;
   chan_type              chan_rdata_ff;
   logic                  chan_rvld_ff;
   logic                  chan_we;
   chan_type              chan_wdata;
   logic                  chan_re;
   logic [2:0]            chan_raddr;
   chan_type              chan_cur;

   // Request decode.
   logic [7:0]  addr_m;
   logic [6:0]  off;
   logic        off_high;
   logic        wave_blocked;
   logic        is_period;
   logic        is_volume;
   logic [7:0]  vol_idx;
   logic [2:0]  wr_ch;
   logic        need_pos;
   logic [2:0]  pos_ch;
   logic [7:0]  adj_addr;
   chan_type    rmw_entry;

   // Tick arithmetic.
   logic [12:0]        divisor;
   logic [14:0]        trial;
   logic               qbit;
   logic [4:0]         new_pos;
   chan_type           wb_entry;
   logic [3:0]         gain;
   logic signed [12:0] mac_prod;
   logic signed [9:0]  contrib;
   logic [11:0]        mag_full;
   logic [15:0]        mix_q;
   logic               rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Entries never written read as their reset values.
   assign wave_cur = wave_rvld_ff ? wave_rdata_ff : 8'd0;
   assign chan_cur = chan_rvld_ff ? chan_rdata_ff : CHAN_RESET;

   // Address decode; bit 4 is ignored in the register half of the map.
   assign addr_m       = {addr_ff[7:5], 1'b0, addr_ff[3:0]};
   assign off          = addr_ff[6:0];
   assign off_high     = (off >= WAVE_SHARED_BASE);
   assign wave_blocked = test_ff[TEST_BLOCK_ALL] | (test_ff[TEST_BLOCK_HIGH] & off_high);
   assign is_period    = (addr_m <= ADDR_PERIOD_LAST);
   assign is_volume    = (addr_m >= ADDR_VOL_FIRST) && (addr_m <= ADDR_VOL_LAST);
   assign vol_idx      = addr_m - ADDR_VOL_FIRST;
   assign wr_ch        = is_period ? addr_m[3:1] : vol_idx[2:0];

   // Test modes can offset a wave read by a channel's current position.
   assign need_pos = (off_high & (test_ff[TEST_BLOCK_HIGH] | test_ff[TEST_BLOCK_ALL]))
                   | test_ff[TEST_BLOCK_ALL];
   always_comb begin
      if (off_high) begin
         pos_ch = test_ff[TEST_BLOCK_ALL] ? CHAN_SHARED : CHAN_PREV_SHARED;
      end else begin
         pos_ch = {1'b0, off[6:5]};
      end
   end
   assign adj_addr = {1'b0, off} + {3'd0, chan_cur.position};

   // Read-modify-write of a channel entry for period and volume writes.
   always_comb begin
      rmw_entry = chan_cur;
      if (is_period) begin
         if (test_ff[TEST_CLEAR_POS]) begin
            rmw_entry.accum    = '0;
            rmw_entry.position = '0;
         end else if (chan_cur.period < PERIOD_MIN_RUN) begin
            rmw_entry.accum = '0;
         end
         if (addr_m[0]) begin
            rmw_entry.period = {wdata_ff[3:0], chan_cur.period[7:0]};
         end else begin
            rmw_entry.period = {chan_cur.period[11:8], wdata_ff};
         end
      end else begin
         rmw_entry.volume = wdata_ff[3:0];
      end
   end

   // One restoring step of (accum + 32) / (period + 1); only the remainder and the
   // low quotient bits are kept, since the position wraps at 32.
   assign divisor = {1'b0, ent_ff.period} + 13'd1;
   assign trial   = {1'b0, rem_ff, dividend_ff[13]} - {2'b0, divisor};
   assign qbit    = ~trial[14];

   assign new_pos = ent_ff.position + quo_ff;
   always_comb begin
      wb_entry          = ent_ff;
      wb_entry.position = new_pos;
      wb_entry.accum    = rem_ff;
   end

   // Channel contribution: floor(wave * volume * key / 8).
   assign gain     = key_ff[ch_ff] ? ent_ff.volume : 4'd0;
   assign mac_prod = $signed({{5{wave_cur[7]}}, wave_cur}) * $signed({9'd0, gain});
   assign contrib  = mac_prod[12:3];

   // Mix magnitude and scaled result; the result never exceeds 30720, so the
   // 32767 clamp cannot trigger.
   assign mag_full = sum_ff[11] ? 12'(-sum_ff) : 12'(sum_ff);
   assign mix_q    = prod_ff[MIX_SHIFT +: 16];

   assign rsp_load = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // Memory port control, driven from the sequencer state.
   always_comb begin
      wave_we    = 1'b0;
      wave_waddr = {1'b0, off};
      wave_re    = 1'b0;
      wave_raddr = {1'b0, off};
      chan_we    = 1'b0;
      chan_wdata = rmw_entry;
      chan_re    = 1'b0;
      chan_raddr = ch_ff;
      case (state_ff)
         S_DISP: begin
            if (cmd_ff == CMD_WRITE) begin
               if (!addr_ff[7]) begin
                  wave_we = !wave_blocked;
               end else if (is_period || is_volume) begin
                  chan_re    = 1'b1;
                  chan_raddr = wr_ch;
               end
            end else if (cmd_ff == CMD_READ && !addr_ff[7]) begin
               if (need_pos) begin
                  chan_re    = 1'b1;
                  chan_raddr = pos_ch;
               end else begin
                  wave_re = 1'b1;
               end
            end
         end
         S_WAVE_WR2: begin
            wave_we    = 1'b1;
            wave_waddr = {CHAN_SHARED, off[4:0]};
         end
         S_CH_RMW: begin
            chan_we = 1'b1;
         end
         S_RD_POS: begin
            wave_re    = 1'b1;
            wave_raddr = adj_addr;
         end
         S_TK_RD: begin
            chan_re = 1'b1;
         end
         S_TK_WB: begin
            chan_we    = 1'b1;
            chan_wdata = wb_entry;
            wave_re    = 1'b1;
            wave_raddr = {ch_ff, new_pos};
         end
         default: begin
         end
      endcase
   end

   // Wave memory; the sequencer never reads and writes the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (wave_we) begin
         wave_mem[wave_waddr] <= wdata_ff;
      end
      if (wave_re) begin
         wave_rdata_ff <= wave_mem[wave_raddr];
         wave_rvld_ff  <= wave_vld_ff[wave_raddr];
      end
   end

   // Wave valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_vld_ff <= '0;
      end else if (wave_we) begin
         wave_vld_ff[wave_waddr] <= 1'b1;
      end
   end

   // Channel memory.
   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_mem[ch_ff] <= chan_wdata;
      end
      if (chan_re) begin
         chan_rdata_ff <= chan_mem[chan_raddr];
         chan_rvld_ff  <= chan_vld_ff[chan_raddr];
      end
   end

   // Channel valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_vld_ff <= '0;
      end else if (chan_we) begin
         chan_vld_ff[ch_ff] <= 1'b1;
      end
   end

   // Sequencer with its datapath and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         test_ff       <= '0;
         key_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {res_sample_ff, res_rdata_ff};
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_tuser;
                  addr_ff  <= req_tdata[7:0];
                  wdata_ff <= req_tdata[15:8];
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               res_rdata_ff  <= '0;
               res_sample_ff <= '0;
               state_ff      <= S_DONE;
               case (cmd_ff)
                  CMD_WRITE: begin
                     if (!addr_ff[7]) begin
                        if (!wave_blocked && off_high) begin
                           state_ff <= S_WAVE_WR2;
                        end
                     end else if (is_period || is_volume) begin
                        ch_ff    <= wr_ch;
                        state_ff <= S_CH_RMW;
                     end else if (addr_m == ADDR_KEY) begin
                        key_ff <= wdata_ff[4:0];
                     end else if (addr_m >= ADDR_TEST) begin
                        test_ff <= wdata_ff;
                     end
                  end
                  CMD_READ: begin
                     if (!addr_ff[7]) begin
                        state_ff <= need_pos ? S_RD_POS : S_RD_WAVE;
                     end else if (addr_m >= ADDR_TEST) begin
                        test_ff      <= TEST_READ_VALUE;
                        res_rdata_ff <= TEST_READ_VALUE;
                     end
                  end
                  CMD_TICK: begin
                     ch_ff    <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_TK_RD;
                  end
                  default: begin
                  end
               endcase
            end
            S_WAVE_WR2: begin
               state_ff <= S_DONE;
            end
            S_CH_RMW: begin
               state_ff <= S_DONE;
            end
            S_RD_POS: begin
               state_ff <= S_RD_WAVE;
            end
            S_RD_WAVE: begin
               res_rdata_ff <= wave_cur;
               state_ff     <= S_DONE;
            end
            S_TK_RD: begin
               state_ff <= S_TK_CHK;
            end
            S_TK_CHK: begin
               // A halted channel neither advances nor contributes.
               ent_ff <= chan_cur;
               if (chan_cur.period < PERIOD_MIN_RUN) begin
                  if (ch_ff == 3'(NUM_CHAN - 1)) begin
                     state_ff <= S_MIX_ABS;
                  end else begin
                     ch_ff    <= ch_ff + 3'd1;
                     state_ff <= S_TK_RD;
                  end
               end else begin
                  dividend_ff <= {1'b0, chan_cur.accum} + ACCUM_STEP;
                  rem_ff      <= '0;
                  quo_ff      <= '0;
                  cnt_ff      <= '0;
                  state_ff    <= S_TK_DIV;
               end
            end
            S_TK_DIV: begin
               dividend_ff <= {dividend_ff[12:0], 1'b0};
               quo_ff      <= {quo_ff[3:0], qbit};
               rem_ff      <= qbit ? trial[12:0] : {rem_ff[11:0], dividend_ff[13]};
               cnt_ff      <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(DIV_STEPS - 1)) begin
                  state_ff <= S_TK_WB;
               end
            end
            S_TK_WB: begin
               state_ff <= S_TK_MAC;
            end
            S_TK_MAC: begin
               sum_ff <= sum_ff + 12'(contrib);
               if (ch_ff == 3'(NUM_CHAN - 1)) begin
                  state_ff <= S_MIX_ABS;
               end else begin
                  ch_ff    <= ch_ff + 3'd1;
                  state_ff <= S_TK_RD;
               end
            end
            S_MIX_ABS: begin
               neg_ff   <= sum_ff[11];
               mag_ff   <= mag_full[10:0];
               state_ff <= S_MIX_MUL;
            end
            S_MIX_MUL: begin
               prod_ff  <= {19'd0, mag_ff} * {11'd0, MIX_RECIP};
               state_ff <= S_MIX_OUT;
            end
            S_MIX_OUT: begin
               // Scaling is done on the magnitude, so it truncates toward zero.
               res_sample_ff <= neg_ff ? -mix_q : mix_q;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ verif/tb_wavetable_sound_generator_5ch.sv @@
module tb_wavetable_sound_generator_5ch;
   timeunit 1ns;
   timeprecision 1ps;

   import wsg5_pkg::*;

   localparam time HALF_PERIOD  = 10ns;
   localparam int  RANDOM_ITEMS = 450;
   localparam int  CYCLE_LIMIT  = 500000;
   localparam int  DRAIN_CYCLES = 200;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  HOLD_AFTER   = 100;
   localparam int  IDLE_PCT     = 21;

   // The request kind that the block does nothing with.
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Response fields as they come back on rsp_tdata.
   typedef struct packed {
      logic [7:0]  rdata;
      logic [15:0] sample;
   } rsp_type;

   // Tracks the sound chip state, predicts each response and checks it on arrival.
   class mix_scoreboard;
      logic [7:0]          wave_mem [WAVE_DEPTH];
      logic [11:0]         period   [NUM_CHAN];
      logic [3:0]          volume   [NUM_CHAN];
      logic [4:0]          position [NUM_CHAN];
      logic [12:0]         accum    [NUM_CHAN];
      logic [NUM_CHAN-1:0] key_mask;
      logic [7:0]          test_bits;
      rsp_type             expected_rsp [$];
      int                  errors;

      function new();
         foreach (wave_mem[i]) wave_mem[i] = '0;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            period[ch]   = '0;
            volume[ch]   = 4'd15;
            position[ch] = '0;
            accum[ch]    = '0;
         end
         key_mask  = '0;
         test_bits = '0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // A bus write updates a wave byte or one of the channel or test registers.
      function void apply_write(logic [7:0] addr, logic [7:0] wdata);
         logic [7:0] folded;
         logic [2:0] ch;
         int         vol_idx;
         if (!addr[7]) begin
            // Test bits can lock out the whole wave memory or only its shared upper part.
            if (test_bits[TEST_BLOCK_ALL] ||
                (test_bits[TEST_BLOCK_HIGH] && addr[6:0] >= WAVE_SHARED_BASE))
               return;
            wave_mem[addr[6:0]] = wdata;
            if (addr[6:0] >= WAVE_SHARED_BASE)
               wave_mem[CHAN_SHARED * WAVE_LEN + addr[4:0]] = wdata;
            return;
         end
         folded = {addr[7:5], 1'b0, addr[3:0]};
         if (folded <= ADDR_PERIOD_LAST) begin
            ch = folded[3:1];
            if (test_bits[TEST_CLEAR_POS]) begin
               accum[ch]    = '0;
               position[ch] = '0;
            end else if (period[ch] < PERIOD_MIN_RUN) begin
               accum[ch] = '0;
            end
            if (folded[0])
               period[ch][11:8] = wdata[3:0];
            else
               period[ch][7:0] = wdata;
         end else if (folded <= ADDR_VOL_LAST) begin
            vol_idx = int'(folded - ADDR_VOL_FIRST);
            volume[vol_idx] = wdata[3:0];
         end else if (folded == ADDR_KEY) begin
            key_mask = wdata[NUM_CHAN-1:0];
         end else if (folded >= ADDR_TEST) begin
            test_bits = wdata;
         end
      endfunction

      // A bus read returns a wave byte, possibly shifted by a channel position.
      function logic [7:0] serve_read(logic [7:0] addr);
         int off;
         if (!addr[7]) begin
            off = int'(addr);
            if (test_bits[TEST_BLOCK_ALL] || test_bits[TEST_BLOCK_HIGH]) begin
               if (off >= WAVE_SHARED_BASE)
                  off += int'(position[test_bits[TEST_BLOCK_ALL] ? CHAN_SHARED
                                                                 : CHAN_PREV_SHARED]);
               else if (test_bits[TEST_BLOCK_ALL])
                  off += int'(position[off >> 5]);
            end
            return wave_mem[off % WAVE_DEPTH];
         end
         // Reading the test register forces it to all ones.
         if ({addr[7:5], 1'b0, addr[3:0]} >= ADDR_TEST) begin
            test_bits = TEST_READ_VALUE;
            return TEST_READ_VALUE;
         end
         return '0;
      endfunction

      // One sample tick: advance every running channel and mix the five voices.
      function logic [15:0] mix_tick();
         int         sum;
         int         total;
         int         c;
         int         gain;
         int         level;
         logic [4:0] pos;
         sum = 0;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (period[ch] < PERIOD_MIN_RUN)
               continue;
            c   = int'(accum[ch]) + 32;
            pos = position[ch];
            while (c > int'(period[ch])) begin
               pos = pos + 5'd1;
               c   = c - int'(period[ch]) - 1;
            end
            position[ch] = pos;
            accum[ch]    = c[12:0];
            level = int'($signed(wave_mem[ch * WAVE_LEN + pos]));
            gain  = key_mask[ch] ? int'(volume[ch]) : 0;
            sum  += (level * gain) >>> 3;
         end
         // Scale by 128/5 with truncation toward zero, then clip.
         total = sum * 128 / 5;
         if (total > 32767)
            total = 32767;
         if (total < -32767)
            total = -32767;
         return total[15:0];
      endfunction

      // Called once per accepted request, in acceptance order.
      function void note_request(logic [1:0] cmd, logic [7:0] addr, logic [7:0] wdata);
         rsp_type rsp;
         rsp = '0;
         case (cmd)
            CMD_WRITE: apply_write(addr, wdata);
            CMD_READ:  rsp.rdata = serve_read(addr);
            CMD_TICK:  rsp.sample = mix_tick();
            default: ;
         endcase
         expected_rsp.push_back(rsp);
      endfunction

      // Compares an accepted response with the oldest prediction.
      function void check_response(logic [7:0] rdata, logic [15:0] sample);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with nothing pending: rdata %h sample %0d",
                     $realtime, rdata, $signed(sample));
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (rdata !== want.rdata) begin
            $display("%0t: rdata mismatch: expected %h, actual %h",
                     $realtime, want.rdata, rdata);
            errors++;
         end
         if (sample !== want.sample) begin
            $display("%0t: sample mismatch: expected %0d, actual %0d",
                     $realtime, $signed(want.sample), $signed(sample));
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] addr, [15:8] wdata
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] rdata, [23:8] sample

   mix_scoreboard board = new();
   int            sent_count  = 0;
   int            cycle_count = 0;
   bit            steady      = 0;

   wavetable_sound_generator_5ch DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Every accepted response is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata[7:0], rsp_tdata[23:8]);
   end

   // Response side: random back-pressure, plus one long hold-off so the block backs up.
   initial begin
      bit held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_count >= HOLD_AFTER) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Offers one request, with optional idle cycles first, and waits for its acceptance.
   // Entered and left at a falling edge.
   task automatic send_request(logic [1:0] cmd, logic [7:0] addr, logic [7:0] wdata);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wdata, addr};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, addr, wdata);
      sent_count++;
      @(negedge clock);
   endtask

   // Draws one request, weighted toward sequences that keep channels running.
   task automatic send_random();
      logic [1:0] cmd;
      logic [7:0] addr;
      logic [7:0] wdata;
      logic [2:0] ch;
      logic       mirror;
      logic       odd;
      int         pick;
      pick   = int'($urandom_range(99));
      cmd    = CMD_WRITE;
      addr   = 8'($urandom_range(255));
      wdata  = 8'($urandom_range(255));
      ch     = 3'($urandom_range(NUM_CHAN - 1));
      mirror = 1'($urandom_range(1));
      odd    = 1'($urandom_range(1));
      if (pick < 30) begin
         cmd = CMD_TICK;
      end else if (pick < 48) begin
         addr = 8'($urandom_range(8'h7f));
      end else if (pick < 58) begin
         cmd  = CMD_READ;
         addr = 8'($urandom_range(8'h7f));
      end else if (pick < 70) begin
         // Period writes; the high nibble is mostly kept at zero so channels move.
         addr = {3'b100, mirror, ch, odd};
         if (odd && $urandom_range(99) < 70)
            wdata = 8'h00;
      end else if (pick < 76) begin
         addr = {3'b100, mirror, 4'ha + 4'(ch)};
      end else if (pick < 81) begin
         addr = {3'b100, mirror, 4'hf};
         if ($urandom_range(99) < 70)
            wdata = 8'h1f;
      end else if (pick < 86) begin
         addr = 8'($urandom_range(8'hff, ADDR_TEST));
         if ($urandom_range(99) < 60)
            wdata = 8'h00;
      end else if (pick < 88) begin
         cmd  = CMD_READ;
         addr = 8'($urandom_range(8'hff, ADDR_TEST));
      end else if (pick < 93) begin
         cmd = CMD_READ;
      end else if (pick < 97) begin
         addr = 8'($urandom_range(8'hdf, 8'ha0));
      end else begin
         cmd = CMD_NONE;
      end
      send_request(cmd, addr, wdata);
   endtask

   // Main sequence: reset, directed requests, random requests, drain.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Most negative wave value at the position every channel reaches on its first tick.
      send_request(CMD_WRITE, 8'h03, 8'h80);
      send_request(CMD_WRITE, 8'h23, 8'h80);
      send_request(CMD_WRITE, 8'h43, 8'h80);
      send_request(CMD_WRITE, 8'h63, 8'h80);
      // Smallest running period on all five channels, the last one through the mirror.
      send_request(CMD_WRITE, 8'h80, 8'h09);
      send_request(CMD_WRITE, 8'h82, 8'h09);
      send_request(CMD_WRITE, 8'h84, 8'h09);
      send_request(CMD_WRITE, 8'h86, 8'h09);
      send_request(CMD_WRITE, 8'h98, 8'h09);
      send_request(CMD_WRITE, ADDR_KEY, 8'h1f);
      send_request(CMD_TICK, 8'h00, 8'h00);
      // Most positive value at the position of the second tick.
      send_request(CMD_WRITE, 8'h06, 8'h7f);
      send_request(CMD_WRITE, 8'h26, 8'h7f);
      send_request(CMD_WRITE, 8'h46, 8'h7f);
      send_request(CMD_WRITE, 8'h66, 8'h7f);
      send_request(CMD_TICK, 8'hff, 8'hff);
      // Halt the shared channel, then work through the test register features.
      send_request(CMD_WRITE, 8'h88, 8'h08);
      send_request(CMD_WRITE, ADDR_TEST, 8'h40);
      send_request(CMD_READ, 8'h10, 8'h00);
      send_request(CMD_WRITE, 8'h05, 8'h55);
      send_request(CMD_WRITE, 8'hff, 8'ha0);
      send_request(CMD_READ, 8'h70, 8'h00);
      send_request(CMD_WRITE, 8'h91, 8'hff);
      send_request(CMD_READ, 8'he7, 8'h00);
      send_request(CMD_NONE, 8'hff, 8'hff);
      send_request(CMD_WRITE, ADDR_TEST, 8'h00);
      send_request(CMD_TICK, 8'h00, 8'h00);

      // Random part, with a stretch free of idle cycles on both sides.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 200 && n < 300);
         send_random();
      end
      steady = 0;
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
